>>> hw/rtl/team_queue_engine_macros.svh
// assertion macros for the team queue engine
// no dependencies; included by the modules that check their own logic
`ifndef TEAM_QUEUE_ENGINE_MACROS_SVH
`define TEAM_QUEUE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define TQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> hw/rtl/tq_pkg.sv
// shared types and constants of the team queue engine
// no dependencies
package tq_pkg;

	localparam int ELEMENTS       = 1024;
	localparam int TEAMS          = 16;
	localparam int SLOTS_PER_TEAM = 64;

	localparam int FUNC_W  = 2;
	localparam int ELEM_W  = 10;
	localparam int TEAM_W  = 4;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 6;
	localparam int TCNT_W  = 7;
	localparam int OCNT_W  = 5;
	localparam int SLOT_AW = TEAM_W + SLOT_W;

	typedef enum logic [FUNC_W-1:0] {
		FN_ASSIGN = 2'd0,
		FN_ENQ    = 2'd1,
		FN_DEQ    = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

endpackage

>>> hw/rtl/tq_cmd_if.sv
// command channel of the team queue engine: valid/ready plus item payload
// depends on tq_pkg
interface tq_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [tq_pkg::FUNC_W-1:0]   func;
	logic [tq_pkg::ELEM_W-1:0]   element;
	logic [tq_pkg::TEAM_W-1:0]   team;

	modport source (output valid, output func, output element, output team, input ready);
	modport sink   (input valid, input func, input element, input team, output ready);
endinterface

>>> hw/rtl/tq_rsp_if.sv
// result channel of the team queue engine: valid/ready plus item payload
// depends on tq_pkg
interface tq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tq_pkg::ELEM_W-1:0]   element_out;
	logic [tq_pkg::STAT_W-1:0]   status;

	modport source (output valid, output element_out, output status, input ready);
	modport sink   (input valid, input element_out, input status, output ready);
endinterface

>>> hw/rtl/team_queue_engine.sv
// team queue engine top: grouped fifo over a team map ram and a slot ram
// depends on tq_pkg, tq_cmd_if, tq_rsp_if, tq_ram and the macros header
// each item: accept and ram read, then update and result in S_EXEC
// the ram reads are registered; S_EXEC stalls while a result is not taken
// a result sits in an output register while the next item is accepted
// reset clears pointers, counts and the team order; ram contents are kept
`include "team_queue_engine_macros.svh"

module team_queue_engine (
	input  logic      clk,
	input  logic      arst_n,
	tq_cmd_if.sink    cmd,
	tq_rsp_if.source  rsp
);
	import tq_pkg::*;

	state_t              state_q, state_d;
	func_t               func_s1;
	logic [ELEM_W-1:0]   elem_s1;

	logic [SLOT_W-1:0]   rptr_q [TEAMS];
	logic [SLOT_W-1:0]   wptr_q [TEAMS];
	logic [TCNT_W-1:0]   tcnt_q [TEAMS];
	logic [TEAM_W-1:0]   order_ring_q [TEAMS];
	logic [TEAM_W-1:0]   ord_rd_q;
	logic [TEAM_W-1:0]   ord_wr_q;
	logic [OCNT_W-1:0]   ord_cnt_q;

	logic                out_valid_q;
	logic [ELEM_W-1:0]   out_elem_q;
	status_t             out_status_q;

	logic                accept;
	logic                exec_go;
	logic [TEAM_W-1:0]   head_team;
	logic [TEAM_W-1:0]   enq_team;
	logic [TEAM_W-1:0]   map_rdata;
	logic [ELEM_W-1:0]   slot_rdata;
	logic                enq_full;
	logic                enq_ok;
	logic                deq_empty;
	logic                deq_ok;
	logic                has_result;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign head_team = order_ring_q[ord_rd_q];
	assign enq_team  = map_rdata;
	assign exec_go   = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);

	assign enq_full   = tcnt_q[enq_team] >= TCNT_W'(SLOTS_PER_TEAM);
	assign enq_ok     = exec_go && (func_s1 == FN_ENQ) && !enq_full;
	assign deq_empty  = (ord_cnt_q == '0) || (tcnt_q[head_team] == '0);
	assign deq_ok     = exec_go && (func_s1 == FN_DEQ) && !deq_empty;
	assign has_result = (func_s1 == FN_DEQ) || ((func_s1 == FN_ENQ) && enq_full);

	// element to team map
	tq_ram #(
		.DEPTH (ELEMENTS),
		.WIDTH (TEAM_W)
	) u_map_ram (
		.clk   (clk),
		.we    (accept && (func_t'(cmd.func) == FN_ASSIGN)),
		.waddr (cmd.element),
		.wdata (cmd.team),
		.re    (accept && (func_t'(cmd.func) == FN_ENQ)),
		.raddr (cmd.element),
		.rdata (map_rdata)
	);

	// per-team element rings
	tq_ram #(
		.DEPTH (TEAMS * SLOTS_PER_TEAM),
		.WIDTH (ELEM_W)
	) u_slot_ram (
		.clk   (clk),
		.we    (enq_ok),
		.waddr ({enq_team, wptr_q[enq_team]}),
		.wdata (elem_s1),
		.re    (accept && (func_t'(cmd.func) == FN_DEQ)),
		.raddr ({head_team, rptr_q[head_team]}),
		.rdata (slot_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (exec_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func_t'(cmd.func);
			elem_s1 <= cmd.element;
		end
	end

	always_ff @(posedge clk) begin
		if (enq_ok && (tcnt_q[enq_team] == '0) && (ord_cnt_q < OCNT_W'(TEAMS))) begin
			order_ring_q[ord_wr_q] <= enq_team;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TEAMS; i++) begin
				rptr_q[i] <= '0;
				wptr_q[i] <= '0;
				tcnt_q[i] <= '0;
			end
			ord_rd_q  <= '0;
			ord_wr_q  <= '0;
			ord_cnt_q <= '0;
		end else if (exec_go && (func_s1 == FN_CLEAR)) begin
			for (int i = 0; i < TEAMS; i++) begin
				rptr_q[i] <= '0;
				wptr_q[i] <= '0;
				tcnt_q[i] <= '0;
			end
			ord_rd_q  <= '0;
			ord_wr_q  <= '0;
			ord_cnt_q <= '0;
		end else if (enq_ok) begin
			wptr_q[enq_team] <= wptr_q[enq_team] + SLOT_W'(1);
			tcnt_q[enq_team] <= tcnt_q[enq_team] + TCNT_W'(1);
			if ((tcnt_q[enq_team] == '0) && (ord_cnt_q < OCNT_W'(TEAMS))) begin
				ord_wr_q  <= ord_wr_q + TEAM_W'(1);
				ord_cnt_q <= ord_cnt_q + OCNT_W'(1);
			end
		end else if (deq_ok) begin
			rptr_q[head_team] <= rptr_q[head_team] + SLOT_W'(1);
			tcnt_q[head_team] <= tcnt_q[head_team] - TCNT_W'(1);
			if (tcnt_q[head_team] == TCNT_W'(1)) begin
				ord_rd_q  <= ord_rd_q + TEAM_W'(1);
				ord_cnt_q <= ord_cnt_q - OCNT_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go && has_result) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && has_result) begin
			if (func_s1 == FN_ENQ) begin
				out_elem_q   <= '0;
				out_status_q <= ST_FULL;
			end else if (deq_empty) begin
				out_elem_q   <= '0;
				out_status_q <= ST_EMPTY;
			end else begin
				out_elem_q   <= slot_rdata;
				out_status_q <= ST_OK;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.element_out = out_elem_q;
	assign rsp.status      = out_status_q;

	`TQ_ASSERT_NXT(a_accept_to_exec, clk, arst_n, accept, state_q == S_EXEC,
		"accepted item did not enter execution")
	`TQ_ASSERT_IMP(a_order_bound, clk, arst_n, 1'b1, ord_cnt_q <= OCNT_W'(TEAMS),
		"team order count beyond team number")
	`TQ_ASSERT_IMP(a_waiting_team_nonempty, clk, arst_n, ord_cnt_q != '0,
		tcnt_q[head_team] != '0, "waiting team holds no element")
	`TQ_ASSERT_IMP(a_error_zero_elem, clk, arst_n,
		out_valid_q && (out_status_q != ST_OK), out_elem_q == '0,
		"error result carries nonzero element")
endmodule

>>> hw/rtl/tq_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
